// ===== src/tvft_pkg.sv =====
// shared types, register codes, states and saturation for the vertical flux tendency block
// no dependencies
package tvft_pkg;

    localparam int MAX_LAYERS_DEF = 64;

    // register indexes on the configuration port
    localparam logic REG_FLUX_ORDER  = 1'b0;
    localparam logic REG_UPWIND_COEF = 1'b1;

    // interior scheme codes
    localparam logic [1:0] FO_UPWIND = 2'd1;
    localparam logic [1:0] FO_FOURTH = 2'd2;

    localparam logic [1:0]  ORDER_RESET = FO_UPWIND;
    localparam logic [16:0] COEF_RESET  = 17'd16384;

    // floor(2^33 / 3): (x/8) * RECIP12 / 2^32 approximates x/12 from below by at most 2
    localparam logic [31:0] RECIP12 = 32'hAAAAAAAA;

    typedef struct packed {
        logic signed [31:0] tracer_value;
        logic        [30:0] layer_thickness;
        logic signed [31:0] interface_velocity;
        logic               last_layer;
    } in_t;

    typedef struct packed {
        logic signed [31:0] tendency_increment;
        logic        [5:0]  layer_number;
        logic               last_result;
    } out_t;

    typedef enum logic [4:0] {
        ST_LOAD, ST_FSTART, ST_FADDR, ST_FDATA,
        ST_SO_M1, ST_SO_M2, ST_SO_A, ST_SO_M3, ST_SO_F,
        ST_HO_G, ST_HO_M1, ST_HO_F1, ST_HO_M2, ST_HO_M3, ST_HO_F2, ST_HO_S,
        ST_DIV_INIT, ST_DIV, ST_DIV_FIX, ST_C12_M, ST_C12_F,
        ST_WR, ST_OADDR, ST_ODATA, ST_OWAIT
    } state_t;

    // clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/tracer_vertical_flux_tendency.sv =====
// top level: column load, shared multiply/divide flux sequencer, tendency output
// depends on tvft_pkg
//
//  channel | ports                          | moves
//  --------+--------------------------------+-----------------------------------
//  input   | s_valid s_ready s_data (in_t)  | one layer per transaction
//  output  | m_valid m_ready m_data (out_t) | one tendency per transaction
//  config  | psel penable pwrite paddr ...  | flux_order at 0, upwind coef at 4
//
// layers load one per cycle; the column ends on last_layer
// each second-order interface goes through the 63-step restoring divider; fourth
// order and third-order upwind instead divide by 12 by reciprocal multiply and a
// small fix-up
// each tendency passes through an address, a data and a wait state and is held until m_ready is high
// s_ready is high only while loading; reset returns to loading with an empty column
module tracer_vertical_flux_tendency
    import tvft_pkg::*;
#(
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_LAYERS);
    localparam int CW = $clog2(MAX_LAYERS + 1);

    // column stores
    logic [31:0] tracer_mem [MAX_LAYERS];
    logic [30:0] thick_mem  [MAX_LAYERS];
    logic [31:0] vel_mem    [MAX_LAYERS];
    logic [31:0] flux_mem   [MAX_LAYERS + 1];

    logic [1:0]  flux_order_reg;
    logic [16:0] coef_reg;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] count_reg, count_next, n_reg, n_next, k_reg, k_next;
    logic [1:0]    fc_reg, fc_next;
    logic          high_reg, high_next;
    logic signed [31:0] t0_reg, t0_next, t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic [30:0]   ha_reg, ha_next, hb_reg, hb_next;
    logic signed [31:0] w_reg, w_next;
    logic signed [63:0] acc_reg, acc_next, q_reg, q_next;
    logic [31:0]   dsr_reg, dsr_next, rem_reg, rem_next;
    logic [62:0]   dvd_reg, dvd_next;
    logic          neg_reg, neg_next;
    logic [5:0]    dcnt_reg, dcnt_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [49:0] f_reg, f_next;
    logic signed [32:0] d_reg, d_next;
    logic signed [31:0] res_reg, res_next, prev_reg, prev_next;
    out_t          m_data_reg, m_data_next;
    logic          m_valid_reg, m_valid_next;

    logic [31:0]   t_rd_reg, w_rd_reg, fl_rd_reg;
    logic [30:0]   h_rd_reg;

    logic          st_we, fl_we;
    logic [CW:0]   t_idx, kp1;
    logic [AW-1:0] t_addr, h_addr;
    logic [CW-1:0] n_val;
    logic          is_high, fetch_done;
    logic signed [32:0] mul_a, mul_b, w_ext, abs_w;
    logic signed [65:0] mul_p;
    logic signed [36:0] s_in, s_out, gnum, d_in, d_out, dnum;
    logic [32:0]   shifted;
    logic signed [63:0] acc_mag;
    logic signed [31:0] cur;
    logic [31:0]   c12_est;
    logic [36:0]   c12_rem;
    logic [32:0]   c12_q;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flux_order_reg <= ORDER_RESET;
            coef_reg       <= COEF_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FLUX_ORDER:  flux_order_reg <= pwdata[1:0];
                REG_UPWIND_COEF: coef_reg       <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_UPWIND_COEF: prdata = {15'd0, coef_reg};
            default:         prdata = {30'd0, flux_order_reg};
        endcase
    end

    // store addressing
    assign kp1    = {1'b0, k_reg} + (CW+1)'(1);
    assign t_idx  = {1'b0, k_reg} + (CW+1)'(fc_reg) - (CW+1)'(2);
    assign t_addr = t_idx[AW-1:0];
    assign h_addr = (fc_reg == 2'd2) ? k_reg[AW-1:0] : AW'(k_reg - CW'(1));
    assign n_val  = (count_reg < CW'(MAX_LAYERS)) ? count_reg + CW'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            tracer_mem[count_reg[AW-1:0]] <= s_data.tracer_value;
            thick_mem[count_reg[AW-1:0]]  <= s_data.layer_thickness;
            vel_mem[count_reg[AW-1:0]]    <= s_data.interface_velocity;
        end
        t_rd_reg <= tracer_mem[t_addr];
        h_rd_reg <= thick_mem[h_addr];
        w_rd_reg <= vel_mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (fl_we) begin
            flux_mem[k_reg] <= res_reg;
        end
        fl_rd_reg <= flux_mem[kp1[CW-1:0]];
    end

    // scheme choice for the current interface
    assign is_high = !(k_reg == CW'(1) || kp1 == {1'b0, n_reg}) &&
                     (flux_order_reg == FO_UPWIND || flux_order_reg == FO_FOURTH);
    assign fetch_done = (fc_reg == (high_reg ? 2'd3 : 2'd2));

    // stencil sums for the high-order schemes
    assign s_in  = 37'(t2_reg) + 37'(t1_reg);
    assign s_out = 37'(t3_reg) + 37'(t0_reg);
    assign gnum  = (s_in <<< 3) - s_in - s_out;
    assign d_in  = 37'(t2_reg) - 37'(t1_reg);
    assign d_out = 37'(t3_reg) - 37'(t0_reg);
    assign dnum  = d_out - ((d_in <<< 1) + d_in);

    assign w_ext   = 33'(w_reg);
    assign abs_w   = w_ext[32] ? -w_ext : w_ext;
    assign acc_mag = acc_reg[63] ? -acc_reg : acc_reg;
    assign shifted = {rem_reg, dvd_reg[62]};
    assign cur     = (kp1 < {1'b0, n_reg}) ? $signed(fl_rd_reg) : 32'sd0;

    // division by 12: estimate from the reciprocal product, then up to two corrections
    assign c12_est = prod_reg[63:32];
    assign c12_rem = 37'(acc_mag[35:0]) - ((37'(c12_est) << 3) + (37'(c12_est) << 2));
    assign c12_q   = (c12_rem >= 37'd24) ? 33'(c12_est) + 33'd2 :
                     (c12_rem >= 37'd12) ? 33'(c12_est) + 33'd1 : 33'(c12_est);

    // the shared multiplier
    assign mul_p = mul_a * mul_b;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        fc_next      = fc_reg;
        high_next    = high_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        ha_next      = ha_reg;
        hb_next      = hb_reg;
        w_next       = w_reg;
        acc_next     = acc_reg;
        q_next       = q_reg;
        dsr_next     = dsr_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        neg_next     = neg_reg;
        dcnt_next    = dcnt_reg;
        prod_next    = prod_reg;
        f_next       = f_reg;
        d_next       = d_reg;
        res_next     = res_reg;
        prev_next    = prev_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        st_we        = 1'b0;
        fl_we        = 1'b0;
        mul_a        = w_ext;
        mul_b        = q_reg[32:0];
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CW'(MAX_LAYERS)) begin
                        st_we      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_data.last_layer) begin
                        n_next     = n_val;
                        count_next = '0;
                        prev_next  = '0;
                        if (n_val > CW'(1)) begin
                            k_next     = CW'(1);
                            state_next = ST_FSTART;
                        end else begin
                            k_next     = '0;
                            state_next = ST_OADDR;
                        end
                    end
                end
            end
            ST_FSTART: begin
                high_next  = is_high;
                fc_next    = is_high ? 2'd0 : 2'd1;
                state_next = ST_FADDR;
            end
            ST_FADDR: state_next = ST_FDATA;
            ST_FDATA: begin
                case (fc_reg)
                    2'd0: t0_next = t_rd_reg;
                    2'd1: begin
                        t1_next = t_rd_reg;
                        ha_next = h_rd_reg;
                    end
                    2'd2: begin
                        t2_next = t_rd_reg;
                        hb_next = h_rd_reg;
                        w_next  = w_rd_reg;
                    end
                    default: t3_next = t_rd_reg;
                endcase
                if (fetch_done) begin
                    state_next = high_reg ? ST_HO_G : ST_SO_M1;
                end else begin
                    fc_next    = fc_reg + 2'd1;
                    state_next = ST_FADDR;
                end
            end
            // second order: weighted average, then times velocity
            ST_SO_M1: begin
                mul_a      = {2'b00, ha_reg};
                mul_b      = 33'(t2_reg);
                prod_next  = mul_p;
                state_next = ST_SO_M2;
            end
            ST_SO_M2: begin
                acc_next   = prod_reg[63:0];
                mul_a      = {2'b00, hb_reg};
                mul_b      = 33'(t1_reg);
                prod_next  = mul_p;
                state_next = ST_SO_A;
            end
            ST_SO_A: begin
                acc_next = acc_reg + prod_reg[63:0];
                dsr_next = {1'b0, ha_reg} + {1'b0, hb_reg};
                if (dsr_next == '0) begin
                    res_next   = '0;
                    state_next = ST_WR;
                end else begin
                    ret_next   = ST_SO_M3;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_SO_M3: begin
                prod_next  = mul_p;
                state_next = ST_SO_F;
            end
            ST_SO_F: begin
                res_next   = sat32(prod_reg >>> 16);
                state_next = ST_WR;
            end
            // high order: centered part, then optional upwind correction
            ST_HO_G: begin
                acc_next   = 64'(gnum);
                ret_next   = ST_HO_M1;
                state_next = ST_C12_M;
            end
            ST_HO_M1: begin
                prod_next  = mul_p;
                state_next = ST_HO_F1;
            end
            ST_HO_F1: begin
                f_next = prod_reg[65:16];
                if (flux_order_reg == FO_UPWIND) begin
                    acc_next   = 64'(dnum);
                    ret_next   = ST_HO_M2;
                    state_next = ST_C12_M;
                end else begin
                    state_next = ST_HO_S;
                end
            end
            ST_HO_M2: begin
                d_next     = q_reg[32:0];
                mul_a      = {16'd0, coef_reg};
                mul_b      = abs_w;
                prod_next  = mul_p;
                state_next = ST_HO_M3;
            end
            ST_HO_M3: begin
                mul_a      = {1'b0, prod_reg[47:16]};
                mul_b      = d_reg;
                prod_next  = mul_p;
                state_next = ST_HO_F2;
            end
            ST_HO_F2: begin
                f_next     = f_reg - prod_reg[65:16];
                state_next = ST_HO_S;
            end
            ST_HO_S: begin
                res_next   = sat32(66'(f_reg));
                state_next = ST_WR;
            end
            // magnitude over 12 by reciprocal multiply, quotient truncated toward zero
            ST_C12_M: begin
                mul_a      = {1'b0, acc_mag[34:3]};
                mul_b      = {1'b0, RECIP12};
                prod_next  = mul_p;
                state_next = ST_C12_F;
            end
            ST_C12_F: begin
                q_next     = acc_reg[63] ? -$signed(64'(c12_q)) : $signed(64'(c12_q));
                state_next = ret_reg;
            end
            // restoring divider on magnitudes, quotient truncated toward zero
            ST_DIV_INIT: begin
                dvd_next   = acc_mag[62:0];
                neg_next   = acc_reg[63];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (shifted >= {1'b0, dsr_reg}) begin
                    rem_next = 32'(shifted - {1'b0, dsr_reg});
                    dvd_next = {dvd_reg[61:0], 1'b1};
                end else begin
                    rem_next = shifted[31:0];
                    dvd_next = {dvd_reg[61:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd62) begin
                    state_next = ST_DIV_FIX;
                end
            end
            ST_DIV_FIX: begin
                q_next     = neg_reg ? -$signed(64'(dvd_reg)) : $signed(64'(dvd_reg));
                state_next = ret_reg;
            end
            ST_WR: begin
                fl_we = 1'b1;
                if (kp1 == {1'b0, n_reg}) begin
                    k_next     = '0;
                    state_next = ST_OADDR;
                end else begin
                    k_next     = kp1[CW-1:0];
                    state_next = ST_FSTART;
                end
            end
            // tendencies, top layer first
            ST_OADDR: state_next = ST_ODATA;
            ST_ODATA: begin
                m_data_next.tendency_increment = sat32(66'(cur) - 66'(prev_reg));
                m_data_next.layer_number       = 6'(k_reg);
                m_data_next.last_result        = (kp1 == {1'b0, n_reg});
                m_valid_next = 1'b1;
                prev_next    = cur;
                state_next   = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (kp1 == {1'b0, n_reg}) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = kp1[CW-1:0];
                        state_next = ST_OADDR;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        fc_reg     <= fc_next;
        high_reg   <= high_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        ha_reg     <= ha_next;
        hb_reg     <= hb_next;
        w_reg      <= w_next;
        acc_reg    <= acc_next;
        q_reg      <= q_next;
        dsr_reg    <= dsr_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        neg_reg    <= neg_next;
        dcnt_reg   <= dcnt_next;
        prod_reg   <= prod_next;
        f_reg      <= f_next;
        d_reg      <= d_next;
        res_reg    <= res_next;
        prev_reg   <= prev_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== src/tvft_checker.sv =====
// port-level checks for the vertical flux tendency block, bound to the top level
// depends on tvft_pkg and tracer_vertical_flux_tendency
module tvft_checker
    import tvft_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no layer is taken while tendencies are being delivered
    a_no_load_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // loading continues until the bottom layer arrives
    a_keep_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last_layer |=> s_ready)
        else $error("load stopped before bottom layer");

    // the column ends on the bottom layer
    a_column_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_layer |=> !s_ready)
        else $error("still loading after bottom layer");

endmodule

bind tracer_vertical_flux_tendency tvft_checker u_tvft_checker (.*);
